// ===== src/ecgrpd_pkg.sv =====
// shared types, widths and helpers of the ecg r-peak detector
`default_nettype none
package ecgrpd_pkg;

  localparam int SMP_W       = 16;
  localparam int TS_W        = 31;
  localparam int GAP_W       = 16;
  localparam int WMAX_W      = 15;
  localparam int ALU_W       = 33;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;
  // moving average length, a power of two so the average is a biased shift
  localparam int AVG_WINDOW  = 32;
  localparam logic [GAP_W-1:0] GAP_RESET = 16'd32;

  typedef logic signed [ALU_W-1:0] alu_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AVG0,
    ST_AVG1,
    ST_AVG2,
    ST_AVG3,
    ST_DIV,
    ST_PMAX,
    ST_SCAN,
    ST_SCANE,
    ST_HDIFF,
    ST_HALF,
    ST_QTR,
    ST_OFF,
    ST_THR,
    ST_CMPA,
    ST_CMPB,
    ST_GAP,
    ST_GAPCMP,
    ST_EMIT
  } state_t;

  function automatic alu_t sext_smp(input logic [SMP_W-1:0] v);
    return {{(ALU_W-SMP_W){v[SMP_W-1]}}, v};
  endfunction

endpackage
`default_nettype wire

// ===== src/ecgrpd_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module ecgrpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== src/ecg_r_peak_detector_core.sv =====
// requests are taken only in idle, after the last result has moved to the output register
// the pace is set by the scan of the max ring (one ram read a cycle) on one shared
// add/compare unit; a result not yet taken holds the sequencer in its last step
// reset: rst_n synchronous active low; rings read as zero until filled, no clearing pass
// min_peak_gap resets to 32, cfg writes are taken in any cycle
`default_nettype none
module ecg_r_peak_detector_core
  import ecgrpd_pkg::*;
#(
  parameter int MAX_WINDOW = 128
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // sample_a [15:0], sample_b [31:16], timestamp [62:32], zero pad [63]
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // moving_average [15:0], window_max [30:16], rr_interval [61:31], zero pad [63:62]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // peak_found [0]
  output logic                        out_tuser,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [GAP_W-1:0]       cfg_data
);

  localparam int AAW   = $clog2(AVG_WINDOW);
  localparam int MAW   = $clog2(MAX_WINDOW);
  localparam int SUM_W = SMP_W + $clog2(AVG_WINDOW);

  state_t state_r, state_nxt;

  logic [SMP_W-1:0]  a_r, b_r;
  logic [TS_W-1:0]   t_r;
  logic [SUM_W-1:0]  sum_r;
  logic [AAW-1:0]    avg_slot_r;
  logic              avg_full_r;
  logic [MAW-1:0]    max_slot_r;
  logic              max_full_r;
  logic [TS_W-1:0]   last_peak_r;
  logic [GAP_W-1:0]  gap_r;
  alu_t              tmp_r, thr_r;
  logic [SMP_W-1:0]  avg_r;
  logic [WMAX_W-1:0] wmax_r;
  logic [MAW-1:0]    scan_idx_r;
  logic              pend_r, ok_r;
  logic              cand_r, peak_r;
  logic [TS_W-1:0]   rr_r;
  logic              out_vld_r;
  logic [SMP_W-1:0]  out_avg_r;
  logic [WMAX_W-1:0] out_wmax_r;
  logic [TS_W-1:0]   out_rr_r;
  logic              out_peak_r;

  // shared add/subtract/compare unit
  alu_t alu_a, alu_b, alu_res;
  logic alu_sub, alu_gt, alu_ge;
  alu_t avg_q;

  logic              avg_wr_en, max_wr_en;
  logic [SMP_W-1:0]  avg_wr_data, max_wr_data;
  logic [SMP_W-1:0]  avg_rd, max_rd;
  logic              out_free;
  logic              in_acc;

  assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
  assign alu_ge  = !alu_res[ALU_W-1];
  assign alu_gt  = alu_ge && (alu_res != '0);
  assign avg_q   = alu_res >>> AAW;

  assign out_free  = !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  ecgrpd_ram #(.WIDTH(SMP_W), .DEPTH(AVG_WINDOW)) u_avg_ram (
    .clk     (clk),
    .wr_en   (avg_wr_en),
    .wr_addr (avg_slot_r),
    .wr_data (avg_wr_data),
    .rd_addr (avg_slot_r),
    .rd_data (avg_rd)
  );

  ecgrpd_ram #(.WIDTH(SMP_W), .DEPTH(MAX_WINDOW)) u_max_ram (
    .clk     (clk),
    .wr_en   (max_wr_en),
    .wr_addr (max_slot_r),
    .wr_data (max_wr_data),
    .rd_addr (scan_idx_r),
    .rd_data (max_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_AVG0;
      ST_AVG0:   state_nxt = ST_AVG1;
      ST_AVG1:   state_nxt = ST_AVG2;
      ST_AVG2:   state_nxt = ST_AVG3;
      ST_AVG3:   state_nxt = ST_DIV;
      ST_DIV:    state_nxt = ST_PMAX;
      ST_PMAX:   state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_idx_r == MAW'(MAX_WINDOW-1)) state_nxt = ST_SCANE;
      ST_SCANE:  state_nxt = ST_HDIFF;
      ST_HDIFF:  state_nxt = ST_HALF;
      ST_HALF:   state_nxt = ST_QTR;
      ST_QTR:    state_nxt = ST_OFF;
      ST_OFF:    state_nxt = ST_THR;
      ST_THR:    state_nxt = ST_CMPA;
      ST_CMPA:   state_nxt = ST_CMPB;
      ST_CMPB:   state_nxt = ST_GAP;
      ST_GAP:    state_nxt = ST_GAPCMP;
      ST_GAPCMP: state_nxt = ST_EMIT;
      ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: alu operands and ram controls
  always_comb begin
    in_tready   = (state_r == ST_IDLE);
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;
    avg_wr_en   = 1'b0;
    avg_wr_data = a_r;
    max_wr_en   = 1'b0;
    max_wr_data = a_r;
    unique case (state_r)
      ST_AVG0, ST_AVG2: begin
        alu_a       = sext_smp((state_r == ST_AVG0) ? a_r : b_r);
        alu_b       = avg_full_r ? sext_smp(avg_rd) : '0;
        alu_sub     = 1'b1;
        avg_wr_en   = 1'b1;
        avg_wr_data = (state_r == ST_AVG0) ? a_r : b_r;
      end
      ST_AVG1, ST_AVG3: begin
        alu_a = {{(ALU_W-SUM_W){sum_r[SUM_W-1]}}, sum_r};
        alu_b = tmp_r;
      end
      // bias a negative sum so the shift truncates toward zero
      ST_DIV: begin
        alu_a = {{(ALU_W-SUM_W){sum_r[SUM_W-1]}}, sum_r};
        alu_b = sum_r[SUM_W-1] ? ALU_W'(AVG_WINDOW-1) : '0;
      end
      ST_PMAX: begin
        alu_a       = sext_smp(a_r);
        alu_b       = sext_smp(b_r);
        alu_sub     = 1'b1;
        max_wr_en   = 1'b1;
        max_wr_data = alu_gt ? a_r : b_r;
      end
      ST_SCAN, ST_SCANE: begin
        alu_a   = sext_smp(max_rd);
        alu_b   = {{(ALU_W-WMAX_W){1'b0}}, wmax_r};
        alu_sub = 1'b1;
      end
      ST_HDIFF: begin
        alu_a   = {{(ALU_W-WMAX_W){1'b0}}, wmax_r};
        alu_b   = sext_smp(avg_r);
        alu_sub = 1'b1;
      end
      // bias negative values so the shift truncates toward zero
      ST_HALF: begin
        alu_a = tmp_r;
        alu_b = tmp_r[ALU_W-1] ? ALU_W'(1) : '0;
      end
      ST_QTR: begin
        alu_a = tmp_r;
        alu_b = tmp_r[ALU_W-1] ? ALU_W'(3) : '0;
      end
      ST_OFF: begin
        alu_a = tmp_r;
        alu_b = thr_r;
      end
      ST_THR: begin
        alu_a = thr_r;
        alu_b = sext_smp(avg_r);
      end
      ST_CMPA, ST_CMPB: begin
        alu_a   = sext_smp((state_r == ST_CMPA) ? a_r : b_r);
        alu_b   = thr_r;
        alu_sub = 1'b1;
      end
      ST_GAP: begin
        alu_a   = {{(ALU_W-TS_W){1'b0}}, t_r};
        alu_b   = {{(ALU_W-TS_W){1'b0}}, last_peak_r};
        alu_sub = 1'b1;
      end
      ST_GAPCMP: begin
        alu_a   = tmp_r;
        alu_b   = {{(ALU_W-GAP_W){1'b0}}, gap_r};
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      avg_slot_r  <= '0;
      avg_full_r  <= 1'b0;
      max_slot_r  <= '0;
      max_full_r  <= 1'b0;
      last_peak_r <= '0;
      gap_r       <= GAP_RESET;
      scan_idx_r  <= '0;
      pend_r      <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        gap_r <= cfg_data;
      end
      if (state_r == ST_EMIT && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_AVG0, ST_AVG2: begin
          if (avg_slot_r == AAW'(AVG_WINDOW-1)) begin
            avg_slot_r <= '0;
            avg_full_r <= 1'b1;
          end else begin
            avg_slot_r <= avg_slot_r + AAW'(1);
          end
        end
        ST_AVG1, ST_AVG3: sum_r <= alu_res[SUM_W-1:0];
        ST_PMAX: begin
          if (max_slot_r == MAW'(MAX_WINDOW-1)) begin
            max_slot_r <= '0;
            max_full_r <= 1'b1;
          end else begin
            max_slot_r <= max_slot_r + MAW'(1);
          end
          pend_r     <= 1'b0;
          scan_idx_r <= '0;
        end
        ST_SCAN: begin
          pend_r <= 1'b1;
          if (scan_idx_r == MAW'(MAX_WINDOW-1)) begin
            scan_idx_r <= '0;
          end else begin
            scan_idx_r <= scan_idx_r + MAW'(1);
          end
        end
        ST_SCANE:  pend_r <= 1'b0;
        ST_GAPCMP: if (cand_r && alu_gt) last_peak_r <= t_r;
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r <= in_tdata[SMP_W-1:0];
      b_r <= in_tdata[2*SMP_W-1:SMP_W];
      t_r <= in_tdata[2*SMP_W+TS_W-1:2*SMP_W];
    end
    unique case (state_r)
      ST_AVG0, ST_AVG2: tmp_r <= alu_res;
      ST_DIV:   avg_r <= avg_q[SMP_W-1:0];
      ST_PMAX:  wmax_r <= '0;
      ST_SCAN: begin
        ok_r <= max_full_r || (scan_idx_r < max_slot_r);
        if (pend_r && ok_r && alu_gt) wmax_r <= max_rd[WMAX_W-1:0];
      end
      ST_SCANE: if (pend_r && ok_r && alu_gt) wmax_r <= max_rd[WMAX_W-1:0];
      ST_HDIFF: tmp_r <= alu_res;
      ST_HALF:  tmp_r <= alu_res >>> 1;
      ST_QTR:   thr_r <= alu_res >>> 2;
      ST_OFF:   thr_r <= alu_res;
      ST_THR:   thr_r <= alu_res;
      ST_CMPA:  cand_r <= alu_gt;
      ST_CMPB:  cand_r <= cand_r || alu_gt;
      ST_GAP:   tmp_r <= alu_res;
      ST_GAPCMP: begin
        peak_r <= cand_r && alu_gt;
        rr_r   <= (cand_r && alu_gt) ? tmp_r[TS_W-1:0] : '0;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_avg_r  <= avg_r;
          out_wmax_r <= wmax_r;
          out_rr_r   <= rr_r;
          out_peak_r <= peak_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_peak_r;
  assign out_tdata  = {{(OUT_TDATA_W-SMP_W-WMAX_W-TS_W){1'b0}}, out_rr_r, out_wmax_r, out_avg_r};

`ifndef SYNTH
  a_accept_starts_avg: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_AVG0)
    else $error("accepted request did not start the average update");

  a_avg_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    avg_full_r |=> avg_full_r)
    else $error("average ring fill flag dropped");

  a_max_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    max_full_r |=> max_full_r)
    else $error("max ring fill flag dropped");

  a_scan_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |=> wmax_r >= $past(wmax_r))
    else $error("window max decreased during scan");

  a_scan_idx_home: assert property (@(posedge clk) disable iff (!rst_n)
    scan_idx_r != '0 |-> state_r == ST_SCAN)
    else $error("scan index left off zero outside the scan");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench of the ecg r-peak detector core: random and directed pairs checked against a predictor
`timescale 1ns / 1ps
module tb_top;
  import ecgrpd_pkg::*;

  localparam int AVG_LEN      = 32;
  localparam int MAX_LEN      = 128;
  localparam int DRAIN_CYCLES = 250;
  localparam int HOLD_CYCLES  = 1200;
  localparam longint TS_MAX   = 64'h7fff_ffff;
  localparam longint TIMEOUT_NS = 64'd12_000_000;

  class rpeak_scoreboard;
    typedef struct {
      logic [SMP_W-1:0]  avg;
      logic [WMAX_W-1:0] wmax;
      logic              peak;
      logic [TS_W-1:0]   rr;
    } rpeak_result_t;

    int avg_hist[AVG_LEN];
    longint avg_total;
    int avg_pos;
    int max_hist[MAX_LEN];
    int max_pos;
    logic [TS_W-1:0] last_peak;
    logic [GAP_W-1:0] gap;
    rpeak_result_t expected_q[$];
    int errors;
    int checked;
    int peaks;

    function new();
      foreach (avg_hist[i]) avg_hist[i] = 0;
      foreach (max_hist[i]) max_hist[i] = 0;
      avg_total = 0;
      avg_pos   = 0;
      max_pos   = 0;
      last_peak = '0;
      gap       = GAP_RESET;
      errors    = 0;
      checked   = 0;
      peaks     = 0;
    endfunction

    function void set_gap(input logic [GAP_W-1:0] g);
      gap = g;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add_sample(input int x);
      avg_total += longint'(x - avg_hist[avg_pos]);
      avg_hist[avg_pos] = x;
      avg_pos = (avg_pos + 1) % AVG_LEN;
    endfunction

    // one accepted request: update windows and predict its result
    function void note_pair(input logic [SMP_W-1:0] a, input logic [SMP_W-1:0] b,
                            input logic [TS_W-1:0] t);
      int sa;
      int sbv;
      int wm;
      longint avg;
      longint half;
      longint offset;
      longint diff;
      rpeak_result_t r;
      sa  = int'($signed(a));
      sbv = int'($signed(b));
      max_hist[max_pos] = (sa > sbv) ? sa : sbv;
      max_pos = (max_pos + 1) % MAX_LEN;
      wm = 0;
      foreach (max_hist[i]) if (max_hist[i] > wm) wm = max_hist[i];
      add_sample(sa);
      add_sample(sbv);
      avg    = avg_total / AVG_LEN;
      half   = (longint'(wm) - avg) / 2;
      offset = half + half / 4;
      diff   = longint'({33'd0, t}) - longint'({33'd0, last_peak});
      r.avg  = avg[SMP_W-1:0];
      r.wmax = wm[WMAX_W-1:0];
      r.peak = ((sa - offset > avg) || (sbv - offset > avg)) && (diff > longint'({48'd0, gap}));
      r.rr   = '0;
      if (r.peak) begin
        r.rr = diff[TS_W-1:0];
        last_peak = t;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(input logic [OUT_TDATA_W-1:0] d, input logic u);
      rpeak_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%b", $time, d, u);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (u) peaks++;
      if (d[15:0] !== e.avg) begin
        $display("%0t: moving_average expected %0d actual %0d", $time,
                 $signed(e.avg), $signed(d[15:0]));
        errors++;
      end
      if (d[30:16] !== e.wmax) begin
        $display("%0t: window_max expected %0d actual %0d", $time, e.wmax, d[30:16]);
        errors++;
      end
      if (u !== e.peak) begin
        $display("%0t: peak_found expected %b actual %b", $time, e.peak, u);
        errors++;
      end
      if (d[61:31] !== e.rr) begin
        $display("%0t: rr_interval expected %0d actual %0d", $time, e.rr, d[61:31]);
        errors++;
      end
      if (d[63:62] !== 2'b00) begin
        $display("%0t: tdata pad expected 0 actual %b", $time, d[63:62]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [GAP_W-1:0] cfg_data = '0;

  rpeak_scoreboard scoreboard = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  longint tick_now = 0;
  int gap_writes = 0;
  int beat_wait = 20;
  int base_lvl = 0;

  ecg_r_peak_detector_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        scoreboard.note_pair(in_tdata[15:0], in_tdata[31:16], in_tdata[62:32]);
      if (out_tvalid && out_tready)
        scoreboard.check_result(out_tdata, out_tuser);
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top failed");
    $finish;
  end

  task automatic send_pair(input logic [SMP_W-1:0] a, input logic [SMP_W-1:0] b,
                           input logic [TS_W-1:0] t);
    in_tdata  <= {1'b0, t, b, a};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic write_gap(input logic [GAP_W-1:0] g);
    cfg_data  <= g;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    scoreboard.set_gap(g);
    gap_writes++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // heartbeat-like pairs: drifting baseline with noise, spikes at random intervals, some junk
  task automatic run_phase(input int count, input int hold_at);
    logic [SMP_W-1:0] a;
    logic [SMP_W-1:0] b;
    logic [TS_W-1:0] t;
    int pick;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      base_lvl += $urandom_range(0, 40) - 20;
      if (base_lvl > 2000) base_lvl = 2000;
      if (base_lvl < -2000) base_lvl = -2000;
      beat_wait--;
      if (pick < 10) begin
        a = SMP_W'($urandom);
        b = SMP_W'($urandom);
      end else if (beat_wait <= 0) begin
        a = SMP_W'($urandom_range(3000, 32767));
        b = SMP_W'($urandom_range(2000, 32767));
        beat_wait = $urandom_range(12, 40);
      end else begin
        a = SMP_W'(base_lvl + $urandom_range(0, 120) - 60);
        b = SMP_W'(base_lvl + $urandom_range(0, 120) - 60);
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        t = TS_W'((tick_now > 500) ? tick_now - $urandom_range(1, 500) : 0);
      end else begin
        if (pick < 8) tick_now += $urandom_range(1000, 100000);
        else tick_now += $urandom_range(0, 40);
        if (tick_now > TS_MAX) tick_now = TS_MAX;
        t = TS_W'(tick_now);
      end
      send_pair(a, b, t);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, gap boundary, time going backwards, start-up windows
    send_pair(16'h0000, 16'h0000, 31'd0);
    send_pair(16'h7fff, 16'h8000, 31'd100);
    send_pair(16'h8000, 16'h7fff, 31'd132);   // exactly the gap after a peak
    send_pair(16'h7fff, 16'h7fff, 31'd133);   // one tick past the gap
    send_pair(16'h8000, 16'h8000, 31'd200);
    send_pair(16'h7fff, 16'h0000, 31'd150);   // time steps back
    send_pair(16'hffff, 16'h0001, 31'd300);
    send_pair(16'h0001, 16'hffff, 31'd301);
    send_pair(16'h5555, 16'haaaa, 31'd700);
    send_pair(16'haaaa, 16'h5555, 31'd900);
    send_pair(16'h8000, 16'h7fff, 31'd0);     // back to time zero
    send_pair(16'h0000, 16'h7ffe, 31'd1000);
    send_pair(16'h8001, 16'h8001, 31'd1001);
    tick_now = 1000;
    settle();

    write_gap(16'h0000);
    run_phase(200, 60);
    settle();
    write_gap(16'hffff);
    run_phase(150, -1);
    settle();
    write_gap(16'($urandom));
    run_phase(200, -1);
    settle();
    write_gap(16'h0001);
    run_phase(150, -1);
    settle();

    // last stretch: no idling, times near the top of the range
    quiet = 1'b1;
    write_gap(16'($urandom_range(0, 600)));
    tick_now = 64'h7fff_0000;
    run_phase(179, -1);
    send_pair(16'h7fff, 16'h7fff, 31'h7fff_ffff);
    settle();

    $display("run covered %0d results, %0d peaks, %0d gap settings plus the reset value",
             scoreboard.checked, scoreboard.peaks, gap_writes);
    $display("mismatches %0d, results still awaited %0d", scoreboard.errors,
             scoreboard.pending());
    if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
